// ===== hdl/efr_pkg.sv =====
package efr_pkg;

    // receive and transmit store depth
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 3;
    localparam int MSG_W    = 7;
    localparam int WIDE_W   = CNT_W + IDX_W;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 24;

    localparam logic [BYTE_W-1:0] HIGH_BIT = 8'h80;

    // operation codes
    localparam logic [OP_W-1:0] OP_LINE_BYTE = 3'd0;
    localparam logic [OP_W-1:0] OP_TX_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_TX_START  = 3'd2;
    localparam logic [OP_W-1:0] OP_TX_END    = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS_RD = 3'd4;
    localparam logic [OP_W-1:0] OP_BUF_RD    = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NODATA   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABORTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOCKED   = 3'd4;

    // register indexes
    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_STOP   = 2'd1;
    localparam logic [1:0] REG_ESCAPE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] stop_code;
        logic [BYTE_W-1:0] escape_code;
    } codes_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] byte_in;
        logic [IDX_W-1:0]  index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data_out;
        logic [MSG_W-1:0]    msg_length;
        logic                frame_open;
        logic                collision;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    // store address taken from an item index
    function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        logic [WIDE_W-1:0] wide;
        wide = {{CNT_W{1'b0}}, idx};
        return wide[ADDR_W-1:0];
    endfunction

endpackage

// ===== hdl/efr_ram.sv =====
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/efr_exec.sv =====
module efr_exec
    import efr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             commit,
    input  item_t            item,
    input  codes_t           codes,
    input  logic [BYTE_W-1:0] tx_q,
    input  logic [BYTE_W-1:0] rx_q,
    output result_t          result,
    output wr_req_t          rx_wr,
    output wr_req_t          tx_wr,
    output logic [CNT_W-1:0] count_next
);

    logic [CNT_W-1:0] rx_count_reg;
    logic             escape_pending_reg, escape_pending_next;
    logic             msg_complete_reg, msg_complete_next;
    logic             overflow_flag_reg, overflow_flag_next;
    logic             tx_active_reg, tx_active_next;
    logic             tx_ok_reg, tx_ok_next;
    logic             frame_flag_reg, frame_flag_next;
    logic [CNT_W-1:0] rx_count_next;

    logic [BYTE_W-1:0] line_val;
    logic [WIDE_W-1:0] idx_wide;
    logic [WIDE_W-1:0] cnt_wide;
    logic              store_room;

    assign line_val   = escape_pending_reg ? (item.byte_in | HIGH_BIT) : item.byte_in;
    assign idx_wide   = {{CNT_W{1'b0}}, item.index};
    assign cnt_wide   = {{IDX_W{1'b0}}, rx_count_reg};
    assign store_room = (cnt_wide < WIDE_W'(BUF_DEPTH));

    // item decode and next state
    always_comb
    begin
        rx_count_next       = rx_count_reg;
        escape_pending_next = escape_pending_reg;
        msg_complete_next   = msg_complete_reg;
        overflow_flag_next  = overflow_flag_reg;
        tx_active_next      = tx_active_reg;
        tx_ok_next          = tx_ok_reg;
        frame_flag_next     = frame_flag_reg;
        result.status       = ST_OK;
        result.data_out     = '0;
        rx_wr.en            = 1'b0;
        rx_wr.addr          = rx_count_reg[ADDR_W-1:0];
        rx_wr.data          = line_val;
        tx_wr.en            = 1'b0;
        tx_wr.addr          = idx_wide[ADDR_W-1:0];
        tx_wr.data          = item.byte_in;
        case (item.op)
            OP_LINE_BYTE:
            begin
                if (item.byte_in == codes.start_code)
                begin
                    if (msg_complete_reg)
                    begin
                        overflow_flag_next = 1'b1;
                        msg_complete_next  = 1'b0;
                    end
                    rx_count_next   = '0;
                    frame_flag_next = 1'b1;
                end
                else if (item.byte_in == codes.stop_code)
                begin
                    if (!tx_active_reg)
                    begin
                        msg_complete_next = 1'b1;
                    end
                    frame_flag_next = 1'b0;
                end
                else if (item.byte_in == codes.escape_code)
                begin
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    escape_pending_next = 1'b0;
                    if (store_room)
                    begin
                        if (tx_active_reg && (tx_q != line_val))
                        begin
                            tx_ok_next = 1'b0;
                        end
                        rx_wr.en      = commit;
                        rx_count_next = rx_count_reg + 1'b1;
                    end
                    else if (tx_active_reg)
                    begin
                        tx_ok_next = 1'b0;
                    end
                end
            end
            OP_TX_LOAD:
            begin
                tx_wr.en = commit && (idx_wide < WIDE_W'(BUF_DEPTH));
            end
            OP_TX_START:
            begin
                if (msg_complete_reg)
                begin
                    result.status = ST_LOCKED;
                end
                else
                begin
                    tx_active_next = 1'b1;
                    tx_ok_next     = 1'b1;
                end
            end
            OP_TX_END:
            begin
                result.status  = (tx_active_reg && tx_ok_reg) ? ST_OK : ST_ABORTED;
                tx_active_next = 1'b0;
                tx_ok_next     = 1'b0;
            end
            OP_STATUS_RD:
            begin
                if (overflow_flag_reg)
                begin
                    overflow_flag_next = 1'b0;
                    result.status      = ST_OVERFLOW;
                end
                else if (msg_complete_reg)
                begin
                    msg_complete_next = 1'b0;
                end
                else
                begin
                    result.status = ST_NODATA;
                end
            end
            OP_BUF_RD:
            begin
                if ((idx_wide < cnt_wide) && (idx_wide < WIDE_W'(BUF_DEPTH)))
                begin
                    result.data_out = rx_q;
                end
                else
                begin
                    result.status = ST_NODATA;
                end
            end
            default:
            begin
            end
        endcase
        result.msg_length = MSG_W'(rx_count_next);
        result.frame_open = frame_flag_next;
        result.collision  = tx_active_next && !tx_ok_next;
    end

    // count after the current item, or held when nothing commits
    assign count_next = commit ? rx_count_next : rx_count_reg;

    // receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg       <= '0;
            escape_pending_reg <= 1'b0;
            msg_complete_reg   <= 1'b0;
            overflow_flag_reg  <= 1'b0;
            tx_active_reg      <= 1'b0;
            tx_ok_reg          <= 1'b0;
            frame_flag_reg     <= 1'b0;
        end
        else if (commit)
        begin
            rx_count_reg       <= rx_count_next;
            escape_pending_reg <= escape_pending_next;
            msg_complete_reg   <= msg_complete_next;
            overflow_flag_reg  <= overflow_flag_next;
            tx_active_reg      <= tx_active_next;
            tx_ok_reg          <= tx_ok_next;
            frame_flag_reg     <= frame_flag_next;
        end
    end

`ifndef SYNTHESIS
    // count saturates at the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        {{IDX_W{1'b0}}, rx_count_reg} <= WIDE_W'(BUF_DEPTH))
        else $error("rx count beyond store depth");

    // transmit check flag only lives inside a transmit
    assert property (@(posedge clk) disable iff (!rst_n)
        !tx_active_reg |-> !tx_ok_reg)
        else $error("tx ok set with no transmit active");

    // status read with overflow pending clears it
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (item.op == OP_STATUS_RD) && overflow_flag_reg) |=> !overflow_flag_reg)
        else $error("overflow not cleared by status read");

    // no store write without a committed item
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_wr.en || tx_wr.en) |-> commit)
        else $error("store write outside commit");
`endif

endmodule

// ===== hdl/escaped_frame_receiver_collision_check_core.sv =====
// registered path: input register, then result register
// throughput: one item per cycle while m_tready does not stall the result register; the stores
// are read at accept, and write/read collisions on the same entry are bypassed
// reset: rst_n is asynchronous, active low; clears control state and sets the
// frame codes to start 253, stop 254, escape 252; store contents are undefined
module escaped_frame_receiver_collision_check_core
    import efr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // byte_in[7:0], index[13:8], zero fill
    input  logic [S_USER_W-1:0] s_tuser,   // op[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status[2:0], data_out[10:3],
                                           // msg_length[17:11], frame_open[18],
                                           // collision[19], zero fill
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [BYTE_W-1:0]   wr_data
);

    codes_t            codes_reg;
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              tx_byp_reg;
    logic [BYTE_W-1:0] tx_byp_data_reg;
    logic              rx_byp_reg;
    logic [BYTE_W-1:0] rx_byp_data_reg;

    item_t             in_item;
    logic              advance;
    logic              accept;
    logic              commit;
    result_t           result;
    wr_req_t           rx_wr;
    wr_req_t           tx_wr;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] tx_raddr;
    logic [ADDR_W-1:0] rx_raddr;
    logic [BYTE_W-1:0] tx_ram_q;
    logic [BYTE_W-1:0] rx_ram_q;
    logic [BYTE_W-1:0] tx_q;
    logic [BYTE_W-1:0] rx_q;

    assign in_item.op      = s_tuser[OP_W-1:0];
    assign in_item.byte_in = s_tdata[BYTE_W-1:0];
    assign in_item.index   = s_tdata[BYTE_W+IDX_W-1:BYTE_W];

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign commit   = s1_valid_reg && advance;

    // frame code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code  <= 8'd253;
            codes_reg.stop_code   <= 8'd254;
            codes_reg.escape_code <= 8'd252;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_START:  codes_reg.start_code  <= wr_data;
                REG_STOP:   codes_reg.stop_code   <= wr_data;
                REG_ESCAPE: codes_reg.escape_code <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // store read addresses: the count after the item now committing, and the item index
    assign tx_raddr = count_next[ADDR_W-1:0];
    assign rx_raddr = idx_to_addr(in_item.index);

    efr_ram #(.WIDTH(BYTE_W), .DEPTH(BUF_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_wr.en),
        .waddr (tx_wr.addr),
        .wdata (tx_wr.data),
        .re    (accept),
        .raddr (tx_raddr),
        .rdata (tx_ram_q)
    );

    efr_ram #(.WIDTH(BYTE_W), .DEPTH(BUF_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_wr.en),
        .waddr (rx_wr.addr),
        .wdata (rx_wr.data),
        .re    (accept),
        .raddr (rx_raddr),
        .rdata (rx_ram_q)
    );

    // input register with write-to-read bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg     <= in_item;
            tx_byp_reg      <= tx_wr.en && (tx_wr.addr == tx_raddr);
            tx_byp_data_reg <= tx_wr.data;
            rx_byp_reg      <= rx_wr.en && (rx_wr.addr == rx_raddr);
            rx_byp_data_reg <= rx_wr.data;
        end
    end

    assign tx_q = tx_byp_reg ? tx_byp_data_reg : tx_ram_q;
    assign rx_q = rx_byp_reg ? rx_byp_data_reg : rx_ram_q;

    efr_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .item       (s1_item_reg),
        .codes      (codes_reg),
        .tx_q       (tx_q),
        .rx_q       (rx_q),
        .result     (result),
        .rx_wr      (rx_wr),
        .tx_wr      (tx_wr),
        .count_next (count_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.collision, out_res_reg.frame_open,
                       out_res_reg.msg_length, out_res_reg.data_out, out_res_reg.status};

endmodule
